### rtl/lru_page_frame_table_unit_defines.svh
// Shared assertion macros.
`ifndef LRU_PAGE_FRAME_TABLE_UNIT_DEFINES_SVH
`define LRU_PAGE_FRAME_TABLE_UNIT_DEFINES_SVH

// Implication property checked on every edge outside reset.
`define LPFT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpft check failed");

// Next-cycle implication property.
`define LPFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpft check failed");

`endif

### rtl/lpft_pkg.sv
package lpft_pkg;

  localparam int Frames   = 16;
  localparam int FrameW   = $clog2(Frames);
  localparam int PinBits  = 8;

  typedef enum logic [1:0] {
    OP_FETCH = 2'd0,
    OP_UNPIN = 2'd1,
    OP_NEW   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_NEW       = 3'd2,
    ST_NO_VICTIM = 3'd3,
    ST_UNPINNED  = 3'd4,
    ST_UNPIN_NM  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] table_id;
    logic [31:0] page_number;
    logic        mark_dirty;
    logic [31:0] allocated_page;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        need_read;
    logic        evict_valid;
    logic [15:0] evict_table;
    logic [31:0] evict_page;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

### rtl/lru_page_frame_table_unit.sv
// Channel | Ports                          | Payload
// input   | in_valid, in_stall, in_data    | lpft_pkg::in_item_t
// result  | out_valid, out_stall, out_data | lpft_pkg::out_item_t
// One request at a time: accept, then a scan of one frame per cycle over all 16 frames,
// a commit step, then the result is held until transferred.
// The next request can be accepted in the cycle after the result transfers.
// Reset empties all frames, clears pins and dirty marks and zeroes the use clock.
// Reserved operation code is taken and dropped without a result.
module lru_page_frame_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpft_pkg::out_item_t out_data
);

  lpft_pkg::dp_cmd_t  cmd;
  lpft_pkg::dp_stat_t stat;

  lpft_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .op(lpft_pkg::op_t'(in_data.operation)), .cmd, .stat
  );

  lpft_datapath u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_data
  );

endmodule

### rtl/lpft_ctrl.sv
module lpft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lpft_pkg::op_t     op,
  output lpft_pkg::dp_cmd_t cmd,
  input  lpft_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && op != lpft_pkg::OP_RSVD) begin
          cmd.load = 1'b1;
          cmd.scan_clear = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### rtl/lpft_datapath.sv
module lpft_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  lpft_pkg::in_item_t in_data,
  input  lpft_pkg::dp_cmd_t  cmd,
  output lpft_pkg::dp_stat_t stat,
  output lpft_pkg::out_item_t out_data
);

  localparam int N  = lpft_pkg::Frames;
  localparam int FW = lpft_pkg::FrameW;
  localparam int PB = lpft_pkg::PinBits;

  logic [N-1:0]  occ_r, dirty_r;
  logic [PB-1:0] pins_r  [N];
  logic [15:0]   tbl_r   [N];
  logic [31:0]   page_r  [N];
  logic [63:0]   stamp_r [N];
  logic [63:0]   clock_r;

  lpft_pkg::in_item_t req_r;
  lpft_pkg::out_item_t res_r;
  lpft_pkg::out_item_t res_nxt;
  logic [FW-1:0] idx_r;
  logic          hit_found_r, empty_found_r, old_found_r;
  logic [FW-1:0] hit_idx_r, empty_idx_r, old_idx_r;
  logic [63:0]   old_stamp_r;
  logic [N-1:0]  match_r;

  logic match_c;
  logic [FW-1:0] vict;
  logic          vict_ok;

  assign stat.scan_last = (idx_r == FW'(N - 1));
  assign out_data = res_r;

  assign match_c = occ_r[idx_r] && tbl_r[idx_r] == req_r.table_id &&
                   page_r[idx_r] == req_r.page_number;

  always_comb begin
    vict_ok = empty_found_r || old_found_r;
    vict    = empty_found_r ? empty_idx_r : old_idx_r;
  end

  always_comb begin
    res_nxt = '0;
    if (req_r.operation == lpft_pkg::OP_UNPIN) begin
      if (hit_found_r) begin
        res_nxt.status = lpft_pkg::ST_UNPINNED;
        res_nxt.frame_index = 4'(hit_idx_r);
      end else begin
        res_nxt.status = lpft_pkg::ST_UNPIN_NM;
      end
    end else if (req_r.operation == lpft_pkg::OP_FETCH && hit_found_r) begin
      res_nxt.status = lpft_pkg::ST_HIT;
      res_nxt.frame_index = 4'(hit_idx_r);
    end else if (!vict_ok) begin
      res_nxt.status = lpft_pkg::ST_NO_VICTIM;
    end else begin
      if (occ_r[vict] && dirty_r[vict]) begin
        res_nxt.evict_valid = 1'b1;
        res_nxt.evict_table = tbl_r[vict];
        res_nxt.evict_page = page_r[vict];
      end
      res_nxt.frame_index = 4'(vict);
      if (req_r.operation == lpft_pkg::OP_FETCH) begin
        res_nxt.status = lpft_pkg::ST_MISS;
        res_nxt.need_read = 1'b1;
      end else begin
        res_nxt.status = lpft_pkg::ST_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.scan_clear) begin
      idx_r <= '0;
      hit_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      old_found_r <= 1'b0;
      match_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      match_r[idx_r] <= match_c;
      if (match_c && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r <= idx_r;
      end
      if (!occ_r[idx_r] && !empty_found_r) begin
        empty_found_r <= 1'b1;
        empty_idx_r <= idx_r;
      end
      if (occ_r[idx_r] && pins_r[idx_r] == '0 &&
          (!old_found_r || stamp_r[idx_r] < old_stamp_r)) begin
        old_found_r <= 1'b1;
        old_idx_r <= idx_r;
        old_stamp_r <= stamp_r[idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      dirty_r <= '0;
      clock_r <= '0;
      for (int i = 0; i < N; i++) pins_r[i] <= '0;
    end else if (cmd.commit) begin
      res_r <= res_nxt;
      if (req_r.operation == lpft_pkg::OP_UNPIN) begin
        for (int i = 0; i < N; i++) begin
          if (match_r[i]) begin
            if (pins_r[i] != '0) pins_r[i] <= pins_r[i] - 1'b1;
            dirty_r[i] <= dirty_r[i] | req_r.mark_dirty;
          end
        end
      end else if (req_r.operation == lpft_pkg::OP_FETCH && hit_found_r) begin
        if (pins_r[hit_idx_r] != '1) pins_r[hit_idx_r] <= pins_r[hit_idx_r] + 1'b1;
        stamp_r[hit_idx_r] <= clock_r;
        clock_r <= clock_r + 64'd1;
      end else if (vict_ok) begin
        occ_r[vict] <= 1'b1;
        tbl_r[vict] <= req_r.table_id;
        pins_r[vict] <= PB'(1);
        stamp_r[vict] <= clock_r;
        clock_r <= clock_r + 64'd1;
        if (req_r.operation == lpft_pkg::OP_FETCH) begin
          page_r[vict] <= req_r.page_number;
          dirty_r[vict] <= 1'b0;
        end else begin
          page_r[vict] <= req_r.allocated_page;
          dirty_r[vict] <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/lpft_checker.sv
`include "lru_page_frame_table_unit_defines.svh"
module lpft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lpft_pkg::out_item_t out_data
);

  `LPFT_ASSERT_IMPL(a_busy_when_out, out_valid, in_stall)
  `LPFT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `LPFT_ASSERT_IMPL(a_status_range, out_valid, out_data.status <= lpft_pkg::ST_UNPIN_NM)
  `LPFT_ASSERT_IMPL(a_read_only_miss, out_valid && out_data.need_read, out_data.status == lpft_pkg::ST_MISS)

endmodule

bind lru_page_frame_table_unit lpft_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);
